[src/rms_pkg.sv]
`default_nettype none

package rms_pkg;

    // Input operation codes
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_STRAIGHT   = 3'd1,
        OP_BACKWARD   = 3'd2,
        OP_TURN_LEFT  = 3'd3,
        OP_TURN_RIGHT = 3'd4,
        OP_STOP       = 3'd5
    } op_t;

    // Motion mode, also reported on motion_mode
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_STRAIGHT = 3'd1,
        MODE_BACK     = 3'd2,
        MODE_LEFT     = 3'd3,
        MODE_RIGHT    = 3'd4
    } mode_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASE_POWER    = 3'd0;
    localparam logic [2:0] CFG_TURN_UNITS    = 3'd1;
    localparam logic [2:0] CFG_UNITS_PER_CM  = 3'd2;
    localparam logic [2:0] CFG_FRONT_STOP    = 3'd3;
    localparam logic [2:0] CFG_BACK_STOP     = 3'd4;
    localparam logic [2:0] CFG_SIDE_NEAR     = 3'd5;

    localparam logic [6:0] POWER_MAX = 7'd100;

    // Balance divisor 50000 = 16 * 3125; ceil(2^32 / 3125) is exact for
    // dividends below 2^20 after the shift by four.
    localparam logic [20:0] BAL_RECIP = 21'd1374390;

    // Word held in the input register
    typedef struct packed {
        logic [2:0]         op;
        logic [14:0]        amount;
        logic signed [32:0] sum;
        logic signed [32:0] diff;
        logic [7:0]         fr;
        logic [7:0]         fl;
        logic [7:0]         br;
        logic [7:0]         bl;
        logic [7:0]         rf;
        logic [7:0]         rb;
        logic [7:0]         lf;
        logic [7:0]         lb;
    } in_word_t;

    // Word held in the prepare register, ready for the state update
    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        lim_prod;
        logic signed [32:0] avg;
        logic signed [32:0] diff;
        logic signed [32:0] ndiff;
        logic               front_block;
        logic               back_block;
        logic signed [9:0]  steer_fwd;
        logic signed [9:0]  steer_bk;
    } prep_word_t;

endpackage

`default_nettype wire

[src/rms_prep.sv]
`default_nettype none

// Per-item arithmetic that needs no motion state: travel limit product,
// average travel, balance quotient, steering offsets and block flags.
module rms_prep (
    input  rms_pkg::in_word_t   in_word,
    input  logic [16:0]         units_per_cm,
    input  logic [15:0]         turn_units_per_degree,
    input  logic [7:0]          front_stop_mm,
    input  logic [7:0]          back_stop_mm,
    input  logic [7:0]          side_near_mm,
    output rms_pkg::prep_word_t prep_word
);

    logic [16:0]        scale;
    logic [31:0]        lim_prod;
    logic signed [32:0] avg_sum;
    logic signed [32:0] avg;
    logic signed [32:0] ndiff;
    logic [32:0]        mag;
    logic [40:0]        recip_prod;
    logic [8:0]         qmag;
    logic signed [9:0]  quot;
    logic signed [8:0]  dr;
    logic signed [8:0]  dl;
    logic               near_rf;
    logic               near_lf;
    logic               near_rb;
    logic               near_lb;
    logic signed [9:0]  steer_fwd;
    logic signed [9:0]  steer_bk;

    // Limit product: cm scale for moves, degree scale for turns
    always_comb
    begin
        if (in_word.op == rms_pkg::OP_STRAIGHT || in_word.op == rms_pkg::OP_BACKWARD)
        begin
            scale = units_per_cm;
        end
        else
        begin
            scale = {1'b0, turn_units_per_degree};
        end
    end

    assign lim_prod = 32'(in_word.amount) * 32'(scale);

    // Average travel, truncated toward zero
    assign avg_sum = in_word.sum + $signed({32'd0, in_word.sum[32]});
    assign avg     = avg_sum >>> 1;

    // Balance quotient diff / 50000 by reciprocal; saturates far beyond power range
    assign ndiff      = -in_word.diff;
    assign mag        = in_word.diff[32] ? ndiff : in_word.diff;
    assign recip_prod = {21'd0, mag[23:4]} * {20'd0, rms_pkg::BAL_RECIP};
    assign qmag       = (mag[32:24] != 9'd0) ? 9'h1FF : recip_prod[40:32];
    assign quot       = in_word.diff[32] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

    // Side wall offsets
    assign dr = $signed({1'b0, in_word.rb}) - $signed({1'b0, in_word.rf});
    assign dl = $signed({1'b0, in_word.lf}) - $signed({1'b0, in_word.lb});

    assign near_rf = in_word.rf < side_near_mm;
    assign near_lf = in_word.lf < side_near_mm;
    assign near_rb = in_word.rb < side_near_mm;
    assign near_lb = in_word.lb < side_near_mm;

    // Steering offset x: left gets base - x, right gets base + x
    always_comb
    begin
        priority if (near_rf)
        begin
            steer_fwd = {dr[8], dr};
        end
        else if (near_lf)
        begin
            steer_fwd = {dl[8], dl};
        end
        else
        begin
            steer_fwd = quot;
        end

        priority if (near_rb)
        begin
            steer_bk = {dr[8], dr};
        end
        else if (near_lb)
        begin
            steer_bk = {dl[8], dl};
        end
        else
        begin
            steer_bk = -quot;
        end
    end

    // Pack the word
    always_comb
    begin
        prep_word.op          = in_word.op;
        prep_word.lim_prod    = lim_prod;
        prep_word.avg         = avg;
        prep_word.diff        = in_word.diff;
        prep_word.ndiff       = ndiff;
        prep_word.front_block = (in_word.fr < front_stop_mm) || (in_word.fl < front_stop_mm);
        prep_word.back_block  = (in_word.br < back_stop_mm) || (in_word.bl < back_stop_mm);
        prep_word.steer_fwd   = steer_fwd;
        prep_word.steer_bk    = steer_bk;
    end

endmodule

`default_nettype wire

[src/robot_motion_sequencer.sv]
// Channel   Handshake             Payload
// --------  --------------------  ---------------------------------------------
// in        in_valid / in_ready   op, amount, left/right_travel, eight ranges
// out       out_valid / out_ready motion_mode, powers, directions, clear_travel,
//                                 just_stopped
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One word per clock sustained while the output is not stalled; an accepted
// word loads the input register, then the prepare register, then the
// result register.
// The motion state updates as a word moves into the result register.
// Reset clears the motion state and loads the configuration defaults.
// A stalled output holds the pipeline back only as far as it is full.
`default_nettype none

module robot_motion_sequencer (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [14:0]        amount,
    input  logic signed [31:0] left_travel,
    input  logic signed [31:0] right_travel,
    input  logic [7:0]         range_front_right,
    input  logic [7:0]         range_front_left,
    input  logic [7:0]         range_back_right,
    input  logic [7:0]         range_back_left,
    input  logic [7:0]         range_right_front,
    input  logic [7:0]         range_right_back,
    input  logic [7:0]         range_left_front,
    input  logic [7:0]         range_left_back,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         motion_mode,
    output logic [6:0]         left_power,
    output logic [6:0]         right_power,
    output logic               left_direction,
    output logic               right_direction,
    output logic               clear_travel,
    output logic               just_stopped,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    // Configuration registers
    logic [6:0]  base_power_reg;
    logic [15:0] turn_units_reg;
    logic [16:0] units_per_cm_reg;
    logic [7:0]  front_stop_reg;
    logic [7:0]  back_stop_reg;
    logic [7:0]  side_near_reg;

    // Pipeline
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    rms_pkg::in_word_t    s1_reg;
    rms_pkg::in_word_t    s1_next;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    rms_pkg::prep_word_t  s2_reg;
    rms_pkg::prep_word_t  s2_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic res_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_fire;
    logic s1_move;
    logic s2_move;

    // Motion state
    rms_pkg::mode_t     mode_reg;
    rms_pkg::mode_t     mode_next;
    logic signed [31:0] travel_limit_reg;
    logic signed [31:0] travel_limit_next;
    logic [6:0]         left_power_reg;
    logic [6:0]         left_power_next;
    logic [6:0]         right_power_reg;
    logic [6:0]         right_power_next;
    logic               left_dir_reg;
    logic               left_dir_next;
    logic               right_dir_reg;
    logic               right_dir_next;
    logic               clear_next;
    logic               stopped_next;

    // Result register
    logic [2:0] out_mode_reg;
    logic [6:0] out_left_power_reg;
    logic [6:0] out_right_power_reg;
    logic       out_left_dir_reg;
    logic       out_right_dir_reg;
    logic       out_clear_reg;
    logic       out_stopped_reg;

    // Update helpers
    logic [6:0]         base_lvl;
    logic signed [31:0] lim_pos;
    logic signed [31:0] lim_neg;
    logic signed [32:0] limit_ext;
    logic               done;
    logic               blocked;
    logic signed [9:0]  steer;
    logic signed [10:0] lp_raw;
    logic signed [10:0] rp_raw;

    function automatic logic [6:0] clamp_power(input logic signed [10:0] v);
        logic [6:0] r;
        if (v[10])
        begin
            r = 7'd0;
        end
        else if (v > $signed({4'd0, rms_pkg::POWER_MAX}))
        begin
            r = rms_pkg::POWER_MAX;
        end
        else
        begin
            r = v[6:0];
        end
        return r;
    endfunction

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_power_reg   <= 7'd80;
            turn_units_reg   <= 16'd19548;
            units_per_cm_reg <= 17'd100000;
            front_stop_reg   <= 8'd55;
            back_stop_reg    <= 8'd40;
            side_near_reg    <= 8'd65;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rms_pkg::CFG_BASE_POWER:   base_power_reg   <= cfg_data[6:0];
                rms_pkg::CFG_TURN_UNITS:   turn_units_reg   <= cfg_data[15:0];
                rms_pkg::CFG_UNITS_PER_CM: units_per_cm_reg <= cfg_data;
                rms_pkg::CFG_FRONT_STOP:   front_stop_reg   <= cfg_data[7:0];
                rms_pkg::CFG_BACK_STOP:    back_stop_reg    <= cfg_data[7:0];
                rms_pkg::CFG_SIDE_NEAR:    side_near_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Handshake chain
    assign res_ready = !out_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || res_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign in_fire   = in_valid && in_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign s2_move   = s2_valid_reg && res_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s2_ready);
    assign s2_valid_next  = s1_move || (s2_valid_reg && !res_ready);
    assign out_valid_next = s2_move || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register word: encoder sum and difference taken exactly
    always_comb
    begin
        s1_next.op     = op;
        s1_next.amount = amount;
        s1_next.sum    = $signed({left_travel[31], left_travel})
                       + $signed({right_travel[31], right_travel});
        s1_next.diff   = $signed({left_travel[31], left_travel})
                       - $signed({right_travel[31], right_travel});
        s1_next.fr     = range_front_right;
        s1_next.fl     = range_front_left;
        s1_next.br     = range_back_right;
        s1_next.bl     = range_back_left;
        s1_next.rf     = range_right_front;
        s1_next.rb     = range_right_back;
        s1_next.lf     = range_left_front;
        s1_next.lb     = range_left_back;
    end

    rms_prep u_prep (
        .in_word               (s1_reg),
        .units_per_cm          (units_per_cm_reg),
        .turn_units_per_degree (turn_units_reg),
        .front_stop_mm         (front_stop_reg),
        .back_stop_mm          (back_stop_reg),
        .side_near_mm          (side_near_reg),
        .prep_word             (s2_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            s2_reg <= s2_next;
        end
    end

    // Motion state update
    assign base_lvl  = (base_power_reg > rms_pkg::POWER_MAX) ? rms_pkg::POWER_MAX
                                                             : base_power_reg;
    assign lim_pos   = s2_reg.lim_prod[31] ? 32'sh7FFF_FFFF : $signed(s2_reg.lim_prod);
    assign lim_neg   = (s2_reg.lim_prod[31] && (s2_reg.lim_prod[30:0] != 31'd0))
                     ? 32'sh8000_0000 : -$signed(s2_reg.lim_prod);
    assign limit_ext = {travel_limit_reg[31], travel_limit_reg};
    assign steer     = (mode_reg == rms_pkg::MODE_STRAIGHT) ? s2_reg.steer_fwd
                                                            : s2_reg.steer_bk;
    assign blocked   = (mode_reg == rms_pkg::MODE_STRAIGHT) ? s2_reg.front_block
                                                            : s2_reg.back_block;
    assign lp_raw    = $signed({4'd0, base_lvl}) - $signed({steer[9], steer});
    assign rp_raw    = $signed({4'd0, base_lvl}) + $signed({steer[9], steer});

    always_comb
    begin
        unique case (mode_reg)
            rms_pkg::MODE_STRAIGHT: done = s2_reg.avg > limit_ext;
            rms_pkg::MODE_BACK:     done = s2_reg.avg < limit_ext;
            rms_pkg::MODE_LEFT:     done = s2_reg.ndiff > limit_ext;
            rms_pkg::MODE_RIGHT:    done = s2_reg.diff > limit_ext;
            default:                done = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next         = mode_reg;
        travel_limit_next = travel_limit_reg;
        left_power_next   = left_power_reg;
        right_power_next  = right_power_reg;
        left_dir_next     = left_dir_reg;
        right_dir_next    = right_dir_reg;
        clear_next        = 1'b0;
        stopped_next      = 1'b0;

        unique case (s2_reg.op)
            rms_pkg::OP_TICK:
            begin
                if (mode_reg != rms_pkg::MODE_IDLE)
                begin
                    priority if (done)
                    begin
                        mode_next         = rms_pkg::MODE_IDLE;
                        travel_limit_next = 32'sd0;
                        left_power_next   = 7'd0;
                        right_power_next  = 7'd0;
                        stopped_next      = 1'b1;
                    end
                    else if (mode_reg == rms_pkg::MODE_STRAIGHT ||
                             mode_reg == rms_pkg::MODE_BACK)
                    begin
                        if (blocked)
                        begin
                            mode_next         = rms_pkg::MODE_IDLE;
                            travel_limit_next = 32'sd0;
                            left_power_next   = 7'd0;
                            right_power_next  = 7'd0;
                            stopped_next      = 1'b1;
                        end
                        else
                        begin
                            left_power_next  = clamp_power(lp_raw);
                            right_power_next = clamp_power(rp_raw);
                        end
                    end
                    else
                    begin
                        // turning, limit not yet reached: powers stay
                    end
                end
            end
            rms_pkg::OP_STRAIGHT:
            begin
                mode_next         = rms_pkg::MODE_STRAIGHT;
                travel_limit_next = lim_pos;
                left_dir_next     = 1'b0;
                right_dir_next    = 1'b0;
                left_power_next   = base_lvl;
                right_power_next  = base_lvl;
                clear_next        = 1'b1;
            end
            rms_pkg::OP_BACKWARD:
            begin
                mode_next         = rms_pkg::MODE_BACK;
                travel_limit_next = lim_neg;
                left_dir_next     = 1'b1;
                right_dir_next    = 1'b1;
                left_power_next   = base_lvl;
                right_power_next  = base_lvl;
                clear_next        = 1'b1;
            end
            rms_pkg::OP_TURN_LEFT:
            begin
                mode_next         = rms_pkg::MODE_LEFT;
                travel_limit_next = $signed(s2_reg.lim_prod);
                left_dir_next     = 1'b0;
                left_power_next   = 7'd0;
                right_power_next  = base_lvl;
                clear_next        = 1'b1;
            end
            rms_pkg::OP_TURN_RIGHT:
            begin
                mode_next         = rms_pkg::MODE_RIGHT;
                travel_limit_next = $signed(s2_reg.lim_prod);
                right_dir_next    = 1'b0;
                left_power_next   = base_lvl;
                right_power_next  = 7'd0;
                clear_next        = 1'b1;
            end
            rms_pkg::OP_STOP:
            begin
                stopped_next      = (mode_reg != rms_pkg::MODE_IDLE);
                mode_next         = rms_pkg::MODE_IDLE;
                travel_limit_next = 32'sd0;
                left_power_next   = 7'd0;
                right_power_next  = 7'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= rms_pkg::MODE_IDLE;
            travel_limit_reg <= 32'sd0;
            left_power_reg   <= 7'd0;
            right_power_reg  <= 7'd0;
            left_dir_reg     <= 1'b0;
            right_dir_reg    <= 1'b0;
        end
        else if (s2_move)
        begin
            mode_reg         <= mode_next;
            travel_limit_reg <= travel_limit_next;
            left_power_reg   <= left_power_next;
            right_power_reg  <= right_power_next;
            left_dir_reg     <= left_dir_next;
            right_dir_reg    <= right_dir_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_mode_reg        <= mode_next;
            out_left_power_reg  <= left_power_next;
            out_right_power_reg <= right_power_next;
            out_left_dir_reg    <= left_dir_next;
            out_right_dir_reg   <= right_dir_next;
            out_clear_reg       <= clear_next;
            out_stopped_reg     <= stopped_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign motion_mode     = out_mode_reg;
    assign left_power      = out_left_power_reg;
    assign right_power     = out_right_power_reg;
    assign left_direction  = out_left_dir_reg;
    assign right_direction = out_right_dir_reg;
    assign clear_travel    = out_clear_reg;
    assign just_stopped    = out_stopped_reg;

    // Checks
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_power <= rms_pkg::POWER_MAX) && (right_power <= rms_pkg::POWER_MAX))
        else $error("motor power above maximum");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == rms_pkg::MODE_IDLE) |->
            (left_power_reg == 7'd0) && (right_power_reg == 7'd0) && (travel_limit_reg == 32'sd0))
        else $error("idle mode with power or limit left set");

    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && just_stopped) |-> !clear_travel && (motion_mode == rms_pkg::MODE_IDLE))
        else $error("stop word reports motion or encoder clear");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_move |=> $stable(mode_reg) && $stable(travel_limit_reg))
        else $error("motion state changed without a word completing");

endmodule

`default_nettype wire
